// ===== rtl/pkt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkt_pkg
// shared types, codes and reset constants of the peer keepalive tracker
// ----------------------------------------------------------------------------
package pkt_pkg;

   typedef enum logic [1:0] {
      SEND_NONE = 2'd0,
      SEND_PING = 2'd1,
      SEND_PONG = 2'd2
   } send_type;

   typedef enum logic [2:0] {
      ST_SHORT  = 3'd0,
      ST_ECHO   = 3'd1,
      ST_PING   = 3'd2,
      ST_PONG   = 3'd3,
      ST_BAD    = 3'd4,
      ST_UPDATE = 3'd5
   } status_type;

   localparam logic ACT_PACKET = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID0          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID1          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID2          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID3          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PING_INTERVAL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVITY_TIMEOUT = 3'd5;

   localparam logic [31:0] PING_INTERVAL_RESET    = 32'd100000;
   localparam logic [31:0] ACTIVITY_TIMEOUT_RESET = 32'd300000;

   // peer_index is four bits wide
   localparam int INDEX_CODES = 16;

   typedef struct packed {
      logic         action;
      logic [3:0]   peer_index;
      logic [10:0]  packet_length;
      logic [7:0]   packet_kind;
      logic [255:0] source;
      logic [31:0]  now;
   } item_type;

   typedef struct packed {
      logic [255:0] own_id;
      logic [31:0]  ping_interval;
      logic [31:0]  activity_timeout;
   } cfg_type;

   typedef struct packed {
      logic        connected;
      logic [31:0] activity;
      logic [31:0] ping;
   } entry_type;

   typedef struct packed {
      logic        wr_conn;
      logic        conn_val;
      logic        wr_act;
      logic        wr_ping;
      logic [31:0] now;
   } update_type;

   typedef struct packed {
      send_type   send_request;
      status_type status;
      logic       connected;
      logic       became_connected;
      logic       became_disconnected;
   } result_type;

endpackage

// ===== rtl/pkt_peer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkt_peer_table
// per-peer connected flag, last activity time and last ping time
// ----------------------------------------------------------------------------
module pkt_peer_table
   import pkt_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] idx,
   input  logic             wr_en,
   input  update_type       upd,
   output entry_type        entry
);

   logic        conn_ff [ENTRIES];
   logic [31:0] act_ff  [ENTRIES];
   logic [31:0] ping_ff [ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            conn_ff[i] <= 1'b0;
            act_ff[i]  <= '0;
            ping_ff[i] <= '0;
         end
      end else if (wr_en) begin
         if (upd.wr_conn) begin
            conn_ff[idx] <= upd.conn_val;
         end
         if (upd.wr_act) begin
            act_ff[idx] <= upd.now;
         end
         if (upd.wr_ping) begin
            ping_ff[idx] <= upd.now;
         end
      end
   end

   assign entry.connected = conn_ff[idx];
   assign entry.activity  = act_ff[idx];
   assign entry.ping      = ping_ff[idx];

endmodule

// ===== rtl/pkt_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkt_eval
// classifies one item against its peer entry and plans the table update
// ----------------------------------------------------------------------------
module pkt_eval
   import pkt_pkg::*;
#(
   parameter int HEADER_BYTES = 40,
   parameter int PING_CODE    = 0,
   parameter int PONG_CODE    = 1
) (
   input  item_type   item,
   input  cfg_type    cfg,
   input  entry_type  entry,
   output update_type upd,
   output result_type res
);

   logic        long_enough;
   logic        is_echo;
   logic        is_ping;
   logic        is_pong;
   logic [31:0] since_ping;
   logic [31:0] since_act;

   assign long_enough = item.packet_length >= 11'(HEADER_BYTES);
   assign is_echo     = item.source == cfg.own_id;
   assign is_ping     = item.packet_kind == 8'(PING_CODE);
   assign is_pong     = item.packet_kind == 8'(PONG_CODE);
   assign since_ping  = item.now - entry.ping;
   assign since_act   = item.now - entry.activity;

   always_comb begin
      upd                     = '0;
      upd.now                 = item.now;
      res.send_request        = SEND_NONE;
      res.status              = ST_SHORT;
      res.connected           = entry.connected;
      res.became_connected    = 1'b0;
      res.became_disconnected = 1'b0;
      if (item.action == ACT_PACKET) begin
         if (long_enough) begin
            upd.wr_act = 1'b1;
            if (is_echo) begin
               res.status = ST_ECHO;
            end else if (is_ping || is_pong) begin
               upd.wr_conn          = 1'b1;
               upd.conn_val         = 1'b1;
               res.connected        = 1'b1;
               res.became_connected = !entry.connected;
               if (is_ping) begin
                  res.send_request = SEND_PONG;
                  res.status       = ST_PING;
               end else begin
                  res.status = ST_PONG;
               end
            end else begin
               res.status = ST_BAD;
            end
         end
      end else begin
         res.status = ST_UPDATE;
         if (since_ping > cfg.ping_interval) begin
            upd.wr_ping      = 1'b1;
            res.send_request = SEND_PING;
         end
         if (entry.connected && (since_act > cfg.activity_timeout)) begin
            upd.wr_conn             = 1'b1;
            upd.conn_val            = 1'b0;
            res.connected           = 1'b0;
            res.became_disconnected = 1'b1;
         end
      end
   end

endmodule

// ===== rtl/peer_keepalive_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_keepalive_tracker_unit
// keepalive liveness tracker: packet and update items against a peer table
//
//   channel  ports            direction  moves
//   req      req_valid/stall  in         one packet or update item
//   rsp      rsp_valid/stall  out        one result per item
//   csr      csr_wr_en        in         register write, no wait
//
// an item passes from the input register to the result register; one item
// per cycle sustained while rsp_stall is low
// the peer table is read and written in the same cycle the item leaves the
// input register, so back to back items on one peer see each other
// reset is synchronous; it clears the table, the csr registers and both valids
// a stalled result holds both stages; req_stall rises only if the input register is full in that case
// ----------------------------------------------------------------------------
module peer_keepalive_tracker_unit
   import pkt_pkg::*;
#(
   parameter int PEERS        = 16,
   parameter int HEADER_BYTES = 40,
   parameter int PING_CODE    = 0,
   parameter int PONG_CODE    = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [3:0]           req_peer_index,
   input  logic [10:0]          req_packet_length,
   input  logic [7:0]           req_packet_kind,
   input  logic [63:0]          req_source_word0,
   input  logic [63:0]          req_source_word1,
   input  logic [63:0]          req_source_word2,
   input  logic [63:0]          req_source_word3,
   input  logic [31:0]          req_now,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_send_request,
   output logic [2:0]           rsp_status,
   output logic                 rsp_connected,
   output logic                 rsp_became_connected,
   output logic                 rsp_became_disconnected,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   localparam int ENTRIES = (PEERS < INDEX_CODES) ? PEERS : INDEX_CODES;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   cfg_type    cfg_ff;
   logic       s1_valid_ff;
   item_type   s1_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic             advance;
   logic             s1_move;
   logic [IDX_W-1:0] idx_map [INDEX_CODES];
   logic [IDX_W-1:0] idx;
   entry_type        entry;
   update_type       upd;
   result_type       res_in;
   item_type         req_item;

   // peer_index modulo the table depth
   for (genvar g = 0; g < INDEX_CODES; g++) begin : g_idx_map
      assign idx_map[g] = IDX_W'(g % ENTRIES);
   end

   assign idx = idx_map[s1_item_ff.peer_index];

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   assign req_item.action        = req_action;
   assign req_item.peer_index    = req_peer_index;
   assign req_item.packet_length = req_packet_length;
   assign req_item.packet_kind   = req_packet_kind;
   assign req_item.source        = {req_source_word3, req_source_word2,
                                    req_source_word1, req_source_word0};
   assign req_item.now           = req_now;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_id           <= '0;
         cfg_ff.ping_interval    <= PING_INTERVAL_RESET;
         cfg_ff.activity_timeout <= ACTIVITY_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OWN_ID0:          cfg_ff.own_id[63:0]     <= csr_data;
            CSR_OWN_ID1:          cfg_ff.own_id[127:64]   <= csr_data;
            CSR_OWN_ID2:          cfg_ff.own_id[191:128]  <= csr_data;
            CSR_OWN_ID3:          cfg_ff.own_id[255:192]  <= csr_data;
            CSR_PING_INTERVAL:    cfg_ff.ping_interval    <= csr_data[31:0];
            CSR_ACTIVITY_TIMEOUT: cfg_ff.activity_timeout <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_item_ff <= req_item;
      end
   end

   pkt_peer_table #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .idx   (idx),
      .wr_en (s1_move),
      .upd   (upd),
      .entry (entry)
   );

   pkt_eval #(
      .HEADER_BYTES (HEADER_BYTES),
      .PING_CODE    (PING_CODE),
      .PONG_CODE    (PONG_CODE)
   ) u_eval (
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .entry (entry),
      .upd   (upd),
      .res   (res_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_send_request        = rsp_ff.send_request;
   assign rsp_status              = rsp_ff.status;
   assign rsp_connected           = rsp_ff.connected;
   assign rsp_became_connected    = rsp_ff.became_connected;
   assign rsp_became_disconnected = rsp_ff.became_disconnected;

endmodule
